>>> hw/rtl/mcu_link_framer_deframer_assert.svh
// ---------------------------------------------------------------------------
// mcu link framer/deframer assertion macros
// concurrent assertion wrappers, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef MCU_LINK_FRAMER_DEFRAMER_ASSERT_SVH
`define MCU_LINK_FRAMER_DEFRAMER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition must hold at every edge out of reset
`define MLD_ASSERT_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MLD_ASSERT_HOLDS(lbl, expr, msg)
`define MLD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> hw/rtl/mld_pkg.sv
// ---------------------------------------------------------------------------
// mld_pkg
// shared types, codes and helpers of the mcu link framer/deframer
// ---------------------------------------------------------------------------
package mld_pkg;

  localparam int MLD_QUEUE_DEPTH = 4;
  localparam int MLD_NUM_WORDS   = 6;

  // command codes
  localparam logic [1:0] CMD_MOTOR  = 2'd0;
  localparam logic [1:0] CMD_SENSOR = 2'd1;
  localparam logic [1:0] CMD_RX     = 2'd2;

  // frame constants
  localparam logic [7:0] FRAME_SOF   = 8'hFF;
  localparam logic [7:0] MOTOR_LEN   = 8'h0A;
  localparam logic [7:0] MOTOR_ID    = 8'h40;
  localparam logic [7:0] SENSOR_LEN  = 8'h04;
  localparam logic [7:0] SENSOR_ID   = 8'h41;
  localparam logic [4:0] ACK_RESP_LEN    = 5'd4;
  localparam logic [4:0] SENSOR_RESP_LEN = 5'd22;
  localparam logic [3:0] MAX_ERR_RESET   = 4'd5;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ECHO    = 2'd1,
    ST_BAD_SUM = 2'd2,
    ST_FAULT   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    JOB_MOTOR  = 2'd0,
    JOB_SENSOR = 2'd1,
    JOB_REPORT = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t                          kind;
    status_t                            status;
    logic [MLD_NUM_WORDS-1:0][15:0]     word;
  } job_t;

  // clip to +-1.0 then scale by 32767/32768 toward zero, which is s - sign(s)
  function automatic logic [15:0] scale_ref(input logic signed [17:0] raw);
    logic signed [17:0] s;
    s = raw;
    if (s > 18'sd32768) s = 18'sd32768;
    if (s < -18'sd32768) s = -18'sd32768;
    if (s > 18'sd0) s = s - 18'sd1;
    else if (s < 18'sd0) s = s + 18'sd1;
    return s[15:0];
  endfunction

  function automatic logic [7:0] motor_check(input logic [MLD_NUM_WORDS-1:0][15:0] w);
    logic [7:0] sum;
    sum = FRAME_SOF + MOTOR_LEN + MOTOR_ID;
    for (int i = 0; i < 3; i++) begin
      sum = sum + w[i][15:8] + w[i][7:0];
    end
    return 8'd0 - sum;
  endfunction

  localparam logic [7:0] SENSOR_CHECK = 8'd0 - (FRAME_SOF + SENSOR_LEN + SENSOR_ID);

endpackage

>>> hw/rtl/mld_front.sv
// ---------------------------------------------------------------------------
// mld_front
// accepts items, tracks the pending response and queues frame/report jobs
// ---------------------------------------------------------------------------
module mld_front
  import mld_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_max_checksum_errors,
  input  logic               in_push,
  input  logic               q_full,
  input  logic [1:0]         in_command,
  input  logic signed [17:0] in_ref_a,
  input  logic signed [17:0] in_ref_b,
  input  logic signed [17:0] in_ref_c,
  input  logic [7:0]         in_rx_byte,
  output logic               q_push,
  output job_t               q_job
);

  typedef enum logic [1:0] {
    AW_IDLE   = 2'd0,
    AW_ACK    = 2'd1,
    AW_SENSOR = 2'd2
  } await_t;

  await_t                         await_r, await_nxt;
  logic [4:0]                     seen_r, seen_nxt;
  logic [7:0]                     sum_r, sum_nxt;
  logic [7:0]                     hold_r, hold_nxt;
  logic [MLD_NUM_WORDS-1:0][15:0] sample_r, sample_nxt;
  logic                           echo_r, echo_nxt;
  logic [3:0]                     bad_cnt_r, bad_cnt_nxt;
  logic [3:0]                     max_err_r;

  logic       accept;
  logic       sensor;
  logic [4:0] need;
  logic [4:0] off;
  logic [2:0] widx;
  status_t    st;

  assign accept = in_push && !q_full;
  assign sensor = (await_r == AW_SENSOR);
  assign need   = sensor ? SENSOR_RESP_LEN : ACK_RESP_LEN;
  assign off    = seen_r - 5'd4;
  assign widx   = off[3:1];

  always_comb begin
    await_nxt   = await_r;
    seen_nxt    = seen_r;
    sum_nxt     = sum_r;
    hold_nxt    = hold_r;
    sample_nxt  = sample_r;
    echo_nxt    = echo_r;
    bad_cnt_nxt = bad_cnt_r;
    st          = ST_OK;
    q_push      = 1'b0;
    q_job       = '0;
    if (accept) begin
      unique case (in_command)
        CMD_MOTOR: begin
          await_nxt   = AW_ACK;
          seen_nxt    = '0;
          sum_nxt     = '0;
          echo_nxt    = 1'b1;
          q_push      = 1'b1;
          q_job.kind  = JOB_MOTOR;
          q_job.word[0] = scale_ref(in_ref_a);
          q_job.word[1] = scale_ref(in_ref_b);
          q_job.word[2] = scale_ref(in_ref_c);
        end
        CMD_SENSOR: begin
          await_nxt  = AW_SENSOR;
          seen_nxt   = '0;
          sum_nxt    = '0;
          echo_nxt   = 1'b1;
          q_push     = 1'b1;
          q_job.kind = JOB_SENSOR;
        end
        CMD_RX: begin
          if (await_r != AW_IDLE) begin
            sum_nxt = sum_r + in_rx_byte;
            if (sensor) begin
              if (seen_r == 5'd2 && in_rx_byte != SENSOR_ID) echo_nxt = 1'b0;
              if (seen_r >= 5'd3 && seen_r <= 5'd14) begin
                if (seen_r[0]) hold_nxt = in_rx_byte;
                else sample_nxt[widx] = {hold_r, in_rx_byte};
              end
            end
            seen_nxt = seen_r + 5'd1;
            if (seen_nxt >= need) begin
              if (sum_nxt == 8'd0) begin
                bad_cnt_nxt = '0;
                st          = ST_OK;
              end else begin
                st = (bad_cnt_r >= max_err_r) ? ST_FAULT : ST_BAD_SUM;
                if (bad_cnt_r != 4'hF) bad_cnt_nxt = bad_cnt_r + 4'd1;
              end
              if (sensor && !echo_nxt) st = ST_ECHO;
              q_push       = 1'b1;
              q_job.kind   = JOB_REPORT;
              q_job.status = st;
              if (sensor) q_job.word = sample_nxt;
              await_nxt = AW_IDLE;
              seen_nxt  = '0;
              sum_nxt   = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_r   <= AW_IDLE;
      seen_r    <= '0;
      sum_r     <= '0;
      hold_r    <= '0;
      sample_r  <= '0;
      echo_r    <= 1'b1;
      bad_cnt_r <= '0;
      max_err_r <= MAX_ERR_RESET;
    end else begin
      await_r   <= await_nxt;
      seen_r    <= seen_nxt;
      sum_r     <= sum_nxt;
      hold_r    <= hold_nxt;
      sample_r  <= sample_nxt;
      echo_r    <= echo_nxt;
      bad_cnt_r <= bad_cnt_nxt;
      if (cfg_we) max_err_r <= cfg_max_checksum_errors;
    end
  end

endmodule

>>> hw/rtl/mld_queue.sv
// ---------------------------------------------------------------------------
// mld_queue
// short job queue between the front and the frame expander
// ---------------------------------------------------------------------------
module mld_queue
  import mld_pkg::*;
#(
  parameter int DEPTH = MLD_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic empty,
  output job_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      if (do_push && !do_pop) count_r <= count_r + CW'(1);
      else if (do_pop && !do_push) count_r <= count_r - CW'(1);
    end
  end

endmodule

>>> hw/rtl/mld_back.sv
// ---------------------------------------------------------------------------
// mld_back
// expands queued jobs into frame bytes and reports behind an output register
// ---------------------------------------------------------------------------
module mld_back
  import mld_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  job_t               q_head,
  output logic               q_pop,
  input  logic               out_pop,
  output logic               out_empty,
  output logic               out_result_kind,
  output logic [7:0]         out_tx_byte,
  output logic               out_tx_last,
  output logic [1:0]         out_status,
  output logic signed [15:0] out_gyro_x,
  output logic signed [15:0] out_gyro_y,
  output logic signed [15:0] out_gyro_z,
  output logic signed [15:0] out_accel_x,
  output logic signed [15:0] out_accel_y,
  output logic signed [15:0] out_accel_z
);

`include "mcu_link_framer_deframer_assert.svh"

  logic [3:0]                     pos_r;
  logic                           valid_r;
  logic                           kind_r;
  logic [7:0]                     byte_r;
  logic                           last_r;
  status_t                        status_r;
  logic [MLD_NUM_WORDS-1:0][15:0] sample_r;

  logic       load;
  logic [3:0] len;
  logic       is_last;
  logic [7:0] byte_sel;

  assign load    = (!valid_r || out_pop) && !q_empty;
  assign is_last = (pos_r == len - 4'd1);
  assign q_pop   = load && is_last;

  always_comb begin
    len      = 4'd1;
    byte_sel = '0;
    unique case (q_head.kind)
      JOB_MOTOR: begin
        len = 4'd10;
        unique case (pos_r)
          4'd0:    byte_sel = FRAME_SOF;
          4'd1:    byte_sel = MOTOR_LEN;
          4'd2:    byte_sel = MOTOR_ID;
          4'd3:    byte_sel = q_head.word[0][15:8];
          4'd4:    byte_sel = q_head.word[0][7:0];
          4'd5:    byte_sel = q_head.word[1][15:8];
          4'd6:    byte_sel = q_head.word[1][7:0];
          4'd7:    byte_sel = q_head.word[2][15:8];
          4'd8:    byte_sel = q_head.word[2][7:0];
          default: byte_sel = motor_check(q_head.word);
        endcase
      end
      JOB_SENSOR: begin
        len = 4'd4;
        unique case (pos_r)
          4'd0:    byte_sel = FRAME_SOF;
          4'd1:    byte_sel = SENSOR_LEN;
          4'd2:    byte_sel = SENSOR_ID;
          default: byte_sel = SENSOR_CHECK;
        endcase
      end
      default: begin
        len      = 4'd1;
        byte_sel = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pos_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        pos_r   <= is_last ? '0 : pos_r + 4'd1;
      end else if (out_pop) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (q_head.kind == JOB_REPORT) begin
        kind_r   <= 1'b1;
        byte_r   <= '0;
        last_r   <= 1'b0;
        status_r <= q_head.status;
        sample_r <= q_head.word;
      end else begin
        kind_r   <= 1'b0;
        byte_r   <= byte_sel;
        last_r   <= is_last;
        status_r <= ST_OK;
        sample_r <= '0;
      end
    end
  end

  assign out_empty       = !valid_r;
  assign out_result_kind = kind_r;
  assign out_tx_byte     = byte_r;
  assign out_tx_last     = last_r;
  assign out_status      = status_r;
  assign out_gyro_x      = sample_r[0];
  assign out_gyro_y      = sample_r[1];
  assign out_gyro_z      = sample_r[2];
  assign out_accel_x     = sample_r[3];
  assign out_accel_y     = sample_r[4];
  assign out_accel_z     = sample_r[5];

  // a partly sent frame keeps its job at the queue head
  `MLD_ASSERT_HOLDS(a_mid_frame_job, (pos_r == 4'd0) || !q_empty, "frame job lost mid-frame")
  `MLD_ASSERT_HOLDS(a_pos_in_frame, q_empty || (pos_r < len), "byte position past frame end")
  `MLD_ASSERT_HOLDS(a_report_no_last, !(valid_r && kind_r && last_r), "report marked frame end")
  `MLD_ASSERT_NEXT(a_last_wraps, load && is_last, (pos_r == 4'd0) && valid_r,
                   "frame end did not restart position")

endmodule

>>> hw/rtl/mcu_link_framer_deframer.sv
// ---------------------------------------------------------------------------
// mcu_link_framer_deframer
// link framer and deframer for the motor-and-imu controller
// ---------------------------------------------------------------------------
// input channel: push/full, one word per accepted item; command 0 sends
//   motor references, 1 requests sensor data, 2 delivers one received byte
// result channel: empty/pop; each word is a transmit byte (result_kind 0)
//   or a response report (result_kind 1) with status and six samples
// configuration: cfg_we writes max_checksum_errors at once
// the front takes one item per cycle while the job queue has room; it
//   updates the response tracker and queues a frame or report job
// the back expands each job into words: 10 for a motor frame, 4 for a
//   sensor request and 1 for a report, one word per cycle unless stalled
// the first result passes the job queue and then the output register
// unstalled output is one word per cycle, so a motor command holds the back
//   for its 10 words and the queue depth sets how far input runs ahead
// when the receiver stalls the output register holds its word, the queue
//   fills and full rises; bytes are never dropped
// reset empties the queue and output, clears the tracker and sets
//   max_checksum_errors to 5
// ---------------------------------------------------------------------------
module mcu_link_framer_deframer
  import mld_pkg::*;
#(
  parameter int QUEUE_DEPTH = MLD_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_max_checksum_errors,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_command,
  input  logic signed [17:0] in_ref_a,
  input  logic signed [17:0] in_ref_b,
  input  logic signed [17:0] in_ref_c,
  input  logic [7:0]         in_rx_byte,
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_result_kind,
  output logic [7:0]         out_tx_byte,
  output logic               out_tx_last,
  output logic [1:0]         out_status,
  output logic signed [15:0] out_gyro_x,
  output logic signed [15:0] out_gyro_y,
  output logic signed [15:0] out_gyro_z,
  output logic signed [15:0] out_accel_x,
  output logic signed [15:0] out_accel_y,
  output logic signed [15:0] out_accel_z
);

  logic q_push, q_pop, q_full, q_empty;
  job_t q_job, q_head;

  assign in_full = q_full;

  mld_front u_front (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_we                  (cfg_we),
    .cfg_max_checksum_errors (cfg_max_checksum_errors),
    .in_push                 (in_push),
    .q_full                  (q_full),
    .in_command              (in_command),
    .in_ref_a                (in_ref_a),
    .in_ref_b                (in_ref_b),
    .in_ref_c                (in_ref_c),
    .in_rx_byte              (in_rx_byte),
    .q_push                  (q_push),
    .q_job                   (q_job)
  );

  mld_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  mld_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_result_kind (out_result_kind),
    .out_tx_byte     (out_tx_byte),
    .out_tx_last     (out_tx_last),
    .out_status      (out_status),
    .out_gyro_x      (out_gyro_x),
    .out_gyro_y      (out_gyro_y),
    .out_gyro_z      (out_gyro_z),
    .out_accel_x     (out_accel_x),
    .out_accel_y     (out_accel_y),
    .out_accel_z     (out_accel_z)
  );

endmodule
